>>> rtl/jts_pkg.sv
// Shared types, character codes and byte classes of the JSON token scanner.
package jts_pkg;

    // Default parameter values
    localparam int POSITION_BITS_DEF = 32;
    localparam int DEPTH_BITS_DEF    = 8;

    // Result queue between scanner and output side
    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = QAW + 1;

    // Number flag bits
    localparam logic [2:0] FL_SIGNED = 3'b001;
    localparam logic [2:0] FL_INT    = 3'b010;
    localparam logic [2:0] FL_FRAC   = 3'b100;

    // Characters
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LC_A     = 8'h61;
    localparam logic [7:0] CH_LC_E     = 8'h65;
    localparam logic [7:0] CH_LC_F     = 8'h66;
    localparam logic [7:0] CH_LC_L     = 8'h6C;
    localparam logic [7:0] CH_LC_N     = 8'h6E;
    localparam logic [7:0] CH_LC_R     = 8'h72;
    localparam logic [7:0] CH_LC_S     = 8'h73;
    localparam logic [7:0] CH_LC_T     = 8'h74;
    localparam logic [7:0] CH_LC_U     = 8'h75;
    localparam logic [7:0] CH_UC_A     = 8'h41;
    localparam logic [7:0] CH_UC_E     = 8'h45;
    localparam logic [7:0] CH_UC_F     = 8'h46;

    // Scan phase
    typedef enum logic [4:0] {
        PH_IDLE, PH_STR, PH_ESC, PH_HEX,
        PH_NSIGN, PH_NZERO, PH_NINT, PH_NFRAC, PH_NEXP, PH_NEXPD,
        PH_TR, PH_TU, PH_TE, PH_FA, PH_FL, PH_FS, PH_FE, PH_NU, PH_NL1, PH_NL2
    } t_phase;

    // Token kinds
    typedef enum logic [3:0] {
        TK_LBRACE, TK_RBRACE, TK_LBRACKET, TK_RBRACKET, TK_STRING,
        TK_COLON, TK_COMMA, TK_UINT, TK_INT, TK_FLOAT,
        TK_TRUE, TK_FALSE, TK_NULL, TK_NONE
    } t_kind;

    // Result status
    typedef enum logic [1:0] {
        ST_OK, ST_INVALID, ST_INCOMPLETE
    } t_status;

    // One result item
    typedef struct packed {
        t_kind              kind;
        t_status            status;
        logic [31:0]        start;
        logic [31:0]        length;
        logic signed [7:0]  depth;
        logic               last;
    } t_result;

    // Results of one byte, handed from scanner to queue
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || ((b >= CH_LC_A) && (b <= CH_LC_F)) ||
               ((b >= CH_UC_A) && (b <= CH_UC_F));
    endfunction

    function automatic logic ends_number(input logic [7:0] b);
        return is_space(b) || (b == CH_COMMA) || (b == CH_RBRACKET) || (b == CH_RBRACE);
    endfunction

endpackage

>>> rtl/jts_ifs.sv
// Valid/ready channel interfaces for text bytes in and tokens out.
interface jts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface jts_out_if;
    logic              valid;
    logic              ready;
    logic [3:0]        token_kind;
    logic [1:0]        status;
    logic [31:0]       token_start;
    logic [31:0]       token_length;
    logic signed [7:0] depth;
    logic              last_of_run;

    modport source (output valid, output token_kind, output status, output token_start,
                    output token_length, output depth, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input status, input token_start,
                    input token_length, input depth, input last_of_run, output ready);
endinterface

>>> rtl/jts_front.sv
// Byte classifier and lexer state machine: turns each byte into up to two results.
module jts_front #(
    parameter int POSITION_BITS = jts_pkg::POSITION_BITS_DEF,
    parameter int DEPTH_BITS    = jts_pkg::DEPTH_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    jts_in_if.sink          i_in,
    input  logic            i_room,
    output jts_pkg::t_push  o_push
);
    import jts_pkg::*;

    localparam int PB  = POSITION_BITS;
    localparam int DW  = DEPTH_BITS;
    localparam int DXW = (DW > 8) ? DW : 8;
    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

    // Scanner state
    t_phase                r_phase, n_phase;
    logic [2:0]            r_hex, n_hex;
    logic [2:0]            r_flags, n_flags;
    logic [PB-1:0]         r_pos, n_pos;
    logic [PB-1:0]         r_start, n_start;
    logic signed [DW-1:0]  r_depth, n_depth;

    logic [7:0] b;
    logic       eod;
    logic       accept;

    // Idle classification of the current byte
    logic                  id_emit;
    t_kind                 id_kind;
    t_status               id_status;
    t_phase                id_phase;
    logic                  id_set_start;
    logic [PB-1:0]         id_start;
    logic                  id_set_flags;
    logic [2:0]            id_flags;
    logic                  id_up;
    logic                  id_down;
    logic signed [DW-1:0]  d_idle;
    logic signed [DW-1:0]  d_after;
    logic signed [7:0]     dq_before;
    logic signed [7:0]     dq_after;

    // Per-phase decisions
    logic     run_idle;
    logic     num_done;
    logic     one_v;
    t_kind    one_kind;
    t_status  one_status;
    logic     one_str;
    logic     kw_hit;
    logic [7:0] kw_want;
    t_phase   kw_next;
    t_kind    kw_kind;

    t_result    res [2];
    logic [1:0] cnt;
    logic [PB-1:0] run_len;

    function automatic logic signed [7:0] clamp8(input logic signed [DW-1:0] d);
        logic signed [DXW-1:0] x;
        x = DXW'(d);
        if (x > DXW'(127)) begin
            return 8'sd127;
        end else if (x < DXW'(-128)) begin
            return -8'sd128;
        end
        return 8'(x);
    endfunction

    assign b        = i_in.data_byte;
    assign eod      = i_in.end_of_data;
    assign i_in.ready = i_room;
    assign accept   = i_in.valid && i_room;
    assign run_len  = r_pos - r_start;

    // Classify a byte seen between tokens
    always_comb begin
        id_emit      = 1'b0;
        id_kind      = TK_NONE;
        id_status    = ST_OK;
        id_phase     = PH_IDLE;
        id_set_start = 1'b0;
        id_start     = r_pos;
        id_set_flags = 1'b0;
        id_flags     = FL_INT;
        id_up        = 1'b0;
        id_down      = 1'b0;
        if (is_space(b)) begin
            id_emit   = eod;
            id_status = ST_INCOMPLETE;
        end else begin
            case (b)
                CH_LBRACE: begin
                    id_emit = 1'b1;
                    id_kind = TK_LBRACE;
                    id_up   = 1'b1;
                end
                CH_RBRACE: begin
                    id_emit = 1'b1;
                    id_kind = TK_RBRACE;
                    id_down = 1'b1;
                end
                CH_LBRACKET: begin
                    id_emit = 1'b1;
                    id_kind = TK_LBRACKET;
                    id_up   = 1'b1;
                end
                CH_RBRACKET: begin
                    id_emit = 1'b1;
                    id_kind = TK_RBRACKET;
                    id_down = 1'b1;
                end
                CH_COLON: begin
                    id_emit = 1'b1;
                    id_kind = TK_COLON;
                end
                CH_COMMA: begin
                    id_emit = 1'b1;
                    id_kind = TK_COMMA;
                end
                CH_QUOTE: begin
                    id_phase     = PH_STR;
                    id_set_start = 1'b1;
                    id_start     = r_pos + PB'(1);
                end
                CH_MINUS: begin
                    id_phase     = PH_NSIGN;
                    id_set_start = 1'b1;
                    id_set_flags = 1'b1;
                    id_flags     = FL_SIGNED;
                end
                CH_LC_T: id_phase = PH_TR;
                CH_LC_F: id_phase = PH_FA;
                CH_LC_N: id_phase = PH_NU;
                default: begin
                    if (is_digit(b)) begin
                        id_phase     = (b == CH_ZERO) ? PH_NZERO : PH_NINT;
                        id_set_start = 1'b1;
                        id_set_flags = 1'b1;
                        id_flags     = FL_INT;
                    end else begin
                        id_emit   = 1'b1;
                        id_status = ST_INVALID;
                    end
                end
            endcase
        end
    end

    // Saturate nesting depth
    always_comb begin
        d_idle = r_depth;
        if (id_up && (r_depth != DMAX)) begin
            d_idle = r_depth + DW'(1);
        end else if (id_down && (r_depth != DMIN)) begin
            d_idle = r_depth - DW'(1);
        end
    end

    assign d_after   = run_idle ? d_idle : r_depth;
    assign dq_before = clamp8(r_depth);
    assign dq_after  = clamp8(d_after);

    // Keyword table: expected byte, follow-up phase and final kind
    always_comb begin
        kw_hit  = 1'b1;
        kw_want = CH_LC_E;
        kw_next = PH_IDLE;
        kw_kind = TK_NONE;
        case (r_phase)
            PH_TR:   begin kw_want = CH_LC_R; kw_next = PH_TU;  end
            PH_TU:   begin kw_want = CH_LC_U; kw_next = PH_TE;  end
            PH_TE:   begin kw_want = CH_LC_E; kw_kind = TK_TRUE; end
            PH_FA:   begin kw_want = CH_LC_A; kw_next = PH_FL;  end
            PH_FL:   begin kw_want = CH_LC_L; kw_next = PH_FS;  end
            PH_FS:   begin kw_want = CH_LC_S; kw_next = PH_FE;  end
            PH_FE:   begin kw_want = CH_LC_E; kw_kind = TK_FALSE; end
            PH_NU:   begin kw_want = CH_LC_U; kw_next = PH_NL1; end
            PH_NL1:  begin kw_want = CH_LC_L; kw_next = PH_NL2; end
            PH_NL2:  begin kw_want = CH_LC_L; kw_kind = TK_NULL; end
            default: kw_hit = 1'b0;
        endcase
    end

    // Advance the scan phase for one byte
    always_comb begin
        n_phase    = r_phase;
        n_hex      = r_hex;
        n_flags    = r_flags;
        run_idle   = 1'b0;
        num_done   = 1'b0;
        one_v      = 1'b0;
        one_kind   = TK_NONE;
        one_status = ST_INVALID;
        one_str    = 1'b0;
        case (r_phase)
            PH_STR: begin
                if (b == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end else if (b == CH_QUOTE) begin
                    one_v      = 1'b1;
                    one_kind   = TK_STRING;
                    one_status = ST_OK;
                    one_str    = 1'b1;
                    n_phase    = PH_IDLE;
                end
            end
            PH_ESC: begin
                if (b == CH_LC_U) begin
                    n_phase = PH_HEX;
                    n_hex   = 3'd4;
                end else begin
                    n_phase = PH_STR;
                end
            end
            PH_HEX: begin
                if (!is_hex(b)) begin
                    one_v   = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_hex = r_hex - 3'd1;
                    if (r_hex == 3'd1) begin
                        n_phase = PH_STR;
                    end
                end
            end
            PH_NSIGN: begin
                if (is_digit(b)) begin
                    n_flags = r_flags | FL_INT;
                    n_phase = (b == CH_ZERO) ? PH_NZERO : PH_NINT;
                end else if (b == CH_DOT) begin
                    n_phase = PH_NFRAC;
                end else begin
                    one_v   = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            PH_NZERO, PH_NINT: begin
                if ((r_phase == PH_NINT) && is_digit(b)) begin
                    n_phase = r_phase;
                end else if (b == CH_DOT) begin
                    n_phase = PH_NFRAC;
                end else if (ends_number(b)) begin
                    num_done = 1'b1;
                    run_idle = 1'b1;
                end else begin
                    one_v   = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            PH_NFRAC: begin
                if (is_digit(b)) begin
                    n_flags = r_flags | FL_FRAC;
                end else if ((b == CH_LC_E) || (b == CH_UC_E) || ends_number(b)) begin
                    if ((r_flags & (FL_INT | FL_FRAC)) == 3'b000) begin
                        one_v   = 1'b1;
                        n_phase = PH_IDLE;
                    end else if (ends_number(b)) begin
                        num_done = 1'b1;
                        run_idle = 1'b1;
                    end else begin
                        n_phase = PH_NEXP;
                    end
                end else begin
                    one_v   = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            PH_NEXP, PH_NEXPD: begin
                if (is_digit(b)) begin
                    n_phase = PH_NEXPD;
                end else if ((r_phase == PH_NEXP) && ((b == CH_MINUS) || (b == CH_PLUS))) begin
                    n_phase = PH_NEXPD;
                end else if (ends_number(b)) begin
                    num_done = 1'b1;
                    run_idle = 1'b1;
                end else begin
                    one_v   = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                if (kw_hit) begin
                    if (b != kw_want) begin
                        one_v   = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = kw_next;
                        if (kw_next == PH_IDLE) begin
                            one_v      = 1'b1;
                            one_kind   = kw_kind;
                            one_status = ST_OK;
                        end
                    end
                end else begin
                    run_idle = 1'b1;
                end
            end
        endcase
        if (run_idle) begin
            n_phase = id_phase;
            if (id_set_flags) begin
                n_flags = id_flags;
            end
        end
    end

    // Collect results and apply end of buffer
    always_comb begin
        n_start = r_start;
        n_depth = d_after;
        n_pos   = r_pos + PB'(1);
        if (run_idle && id_set_start) begin
            n_start = id_start;
        end
        res[0] = '0;
        res[1] = '0;
        cnt    = 2'd0;
        if (num_done) begin
            res[0].kind   = ((r_phase == PH_NFRAC) || (r_phase == PH_NEXP) ||
                             (r_phase == PH_NEXPD)) ? TK_FLOAT :
                            ((r_flags & FL_SIGNED) != 3'b000) ? TK_INT : TK_UINT;
            res[0].status = ST_OK;
            res[0].start  = 32'(r_start);
            res[0].length = 32'(run_len);
            res[0].depth  = dq_before;
            cnt           = 2'd1;
        end
        if (one_v) begin
            res[cnt[0]].kind   = one_kind;
            res[cnt[0]].status = one_status;
            res[cnt[0]].start  = one_str ? 32'(r_start) : 32'd0;
            res[cnt[0]].length = one_str ? 32'(run_len) : 32'd0;
            res[cnt[0]].depth  = dq_after;
            cnt                = cnt + 2'd1;
        end
        if (run_idle && id_emit) begin
            res[cnt[0]].kind   = id_kind;
            res[cnt[0]].status = id_status;
            res[cnt[0]].depth  = dq_after;
            cnt                = cnt + 2'd1;
        end
        if (eod) begin
            if (n_phase != PH_IDLE) begin
                res[cnt[0]].kind   = TK_NONE;
                res[cnt[0]].status = ST_INCOMPLETE;
                res[cnt[0]].depth  = dq_after;
                cnt                = cnt + 2'd1;
            end
            n_start = '0;
            n_depth = '0;
            n_pos   = '0;
        end
        if (cnt != 2'd0) begin
            res[cnt[1]].last = 1'b1;
        end
    end

    assign o_push.count  = accept ? cnt : 2'd0;
    assign o_push.first  = res[0];
    assign o_push.second = res[1];

    // Update scanner state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hex   <= '0;
            r_flags <= '0;
            r_pos   <= '0;
            r_start <= '0;
            r_depth <= '0;
        end else if (accept) begin
            r_phase <= eod ? PH_IDLE : n_phase;
            r_hex   <= eod ? 3'd0 : n_hex;
            r_flags <= eod ? 3'b000 : n_flags;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_depth <= n_depth;
        end
    end

`ifndef ASSERT_OFF
    a_hex_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEX) |-> ((r_hex != 3'd0) && (r_hex <= 3'd4)))
        else $error("hex digit count out of range in escape");

    a_int_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_NZERO) || (r_phase == PH_NINT)) |-> ((r_flags & FL_INT) != 3'b000))
        else $error("integer phase without integer flag");

    a_buffer_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && eod) |=> ((r_pos == '0) && (r_phase == PH_IDLE) && (r_depth == '0)))
        else $error("state not cleared after last byte of buffer");
`endif

endmodule

>>> rtl/jts_queue.sv
// Result queue: takes up to two results a cycle, sends one a cycle if o_out.ready.
module jts_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  jts_pkg::t_push i_push,
    output logic           o_room,
    jts_out_if.source      o_out
);
    import jts_pkg::*;

    t_result        r_mem [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QCW-1:0] r_count, n_count;
    logic           pop;
    t_result        head;

    assign head   = r_mem[r_rd];
    assign pop    = o_out.valid && o_out.ready;
    assign o_room = (r_count <= QCW'(QUEUE_DEPTH - 2));

    // Drive the output channel from the queue head
    assign o_out.valid        = (r_count != '0);
    assign o_out.token_kind   = head.kind;
    assign o_out.status       = head.status;
    assign o_out.token_start  = head.start;
    assign o_out.token_length = head.length;
    assign o_out.depth        = head.depth;
    assign o_out.last_of_run  = head.last;

    // Advance pointers and fill level
    always_comb begin
        n_wr    = r_wr + QAW'(i_push.count);
        n_rd    = r_rd + QAW'(pop);
        n_count = r_count + QCW'(i_push.count) - QCW'(pop);
    end

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + QAW'(1)] <= i_push.second;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("results pushed without room");

    a_pop_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (i_push.count == 2'd0)) |=> (r_count == $past(r_count) - QCW'(1)))
        else $error("fill level did not drop on a lone pop");
`endif

endmodule

>>> rtl/json_token_scanner.sv
// JSON token scanner top level: byte input channel, token output channel.
//
// i_in carries one byte of JSON text per transaction, with end_of_data set on
// the last byte of a buffer; position and depth restart at zero after it.
// o_out carries one token result per transaction: kind, status, start and
// length (strings and numbers), nesting depth, and last_of_run on the final
// result caused by a byte. A byte causes zero, one or two results.
// Results are registered in the result queue and sent on o_out from its head.
// Throughput: one byte per cycle while results drain at one per cycle; a
// byte that causes two results leaves one in the four-entry result queue.
// i_in.ready is high whenever the queue has two free entries, so a waiting
// result does not block the next byte.
// When the receiver stalls, the queue fills and i_in.ready drops until
// space is freed; no result is lost or repeated.
// Reset clears the scanner to idle at position zero, depth zero, and empties
// the queue.
module json_token_scanner #(
    parameter int POSITION_BITS = jts_pkg::POSITION_BITS_DEF,
    parameter int DEPTH_BITS    = jts_pkg::DEPTH_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jts_in_if.sink    i_in,
    jts_out_if.source o_out
);
    import jts_pkg::*;

    t_push push;
    logic  room;

    // Classify bytes and run the lexer
    jts_front #(
        .POSITION_BITS (POSITION_BITS),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push)
    );

    // Queue results and send them out
    jts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

>>> test/tb_json_token_scanner.sv
// Self-checking JSON token scanner bench: directed table, random text, deep nesting.
`timescale 1ns / 100ps

module tb_json_token_scanner;
    import jts_pkg::*;

    localparam int DIRECTED_ROWS = 25;
    localparam int DEEP_RUN      = 132;
    localparam int LONG_HOLD     = 60;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;

    // One directed byte; the expectation is typed in only where typed is set
    typedef struct packed {
        logic [7:0]        code;
        logic              eod;
        logic              typed;
        t_kind             w_kind;
        t_status           w_status;
        logic signed [7:0] w_depth;
    } t_row;

    localparam t_row PLAN [DIRECTED_ROWS] = '{
        '{CH_LBRACE,   1'b0, 1'b1, TK_LBRACE,   ST_OK,         8'sd1},
        '{CH_QUOTE,    1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_BSLASH,   1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_LC_U,     1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_UC_F,     1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_ZERO,     1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_LC_A,     1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_NINE,     1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_QUOTE,    1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_COLON,    1'b0, 1'b1, TK_COLON,    ST_OK,         8'sd1},
        '{CH_MINUS,    1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_ZERO,     1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_DOT,      1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_ZERO + 8'd5, 1'b0, 1'b0, TK_NONE,  ST_OK,         8'sd0},
        '{CH_UC_E,     1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_PLUS,     1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_ZERO + 8'd7, 1'b0, 1'b0, TK_NONE,  ST_OK,         8'sd0},
        '{CH_RBRACE,   1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{8'hFF,       1'b0, 1'b1, TK_NONE,     ST_INVALID,    8'sd0},
        '{CH_LBRACKET, 1'b0, 1'b1, TK_LBRACKET, ST_OK,         8'sd1},
        '{CH_LC_N,     1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_LC_U,     1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_LC_L,     1'b0, 1'b0, TK_NONE,     ST_OK,         8'sd0},
        '{CH_LC_L,     1'b0, 1'b1, TK_NULL,     ST_OK,         8'sd1},
        '{CH_SPACE,    1'b1, 1'b1, TK_NONE,     ST_INCOMPLETE, 8'sd1}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    jts_in_if  in_if ();
    jts_out_if out_if ();

    json_token_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #4 i_clk = ~i_clk;

    // Scanner model state
    t_phase            scan_ph;
    logic [2:0]        hex_todo;
    logic [2:0]        num_bits;
    logic [31:0]       cur_pos;
    logic [31:0]       tok_begin;
    logic signed [7:0] nest_level;

    t_result    byte_toks[$];    // tokens caused by the byte being scanned
    t_result    tokens_due[$];   // tokens still owed by the scanner
    logic [7:0] pending_text[$]; // random text waiting to be sent

    logic    row_typed;
    t_result row_want;
    int      err_count   = 0;
    int      cycle_count = 0;
    int      random_sent = 0;
    bit      tx_calm     = 1'b0;
    bit      hold_req    = 1'b0;
    bit      hold_done   = 1'b0;

    // ---------------------------------------------------------------- model

    function automatic bit blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic bit numeral(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit hexit(input logic [7:0] b);
        return numeral(b) || (b >= CH_LC_A && b <= CH_LC_F) || (b >= CH_UC_A && b <= CH_UC_F);
    endfunction

    function automatic bit closes_num(input logic [7:0] b);
        return blank(b) || b == CH_COMMA || b == CH_RBRACKET || b == CH_RBRACE;
    endfunction

    function automatic void reset_scan();
        scan_ph    = PH_IDLE;
        hex_todo   = '0;
        num_bits   = '0;
        cur_pos    = '0;
        tok_begin  = '0;
        nest_level = '0;
    endfunction

    function automatic void emit_tok(input t_kind k, input t_status s,
                                     input logic [31:0] st, input logic [31:0] len);
        t_result r;
        r.kind   = k;
        r.status = s;
        r.start  = st;
        r.length = len;
        r.depth  = nest_level;
        r.last   = 1'b0;
        byte_toks.insert(byte_toks.size(), r);
    endfunction

    // Move nesting depth, saturating at the signed 8-bit range
    function automatic void shift_nest(input int delta);
        int v;
        v = int'(nest_level) + delta;
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        nest_level = 8'(v);
    endfunction

    function automatic void reject();
        scan_ph = PH_IDLE;
        emit_tok(TK_NONE, ST_INVALID, '0, '0);
    endfunction

    function automatic void idle_step(input logic [7:0] b, input logic [31:0] p,
                                      input logic eod);
        if (blank(b)) begin
            if (eod) emit_tok(TK_NONE, ST_INCOMPLETE, '0, '0);
            return;
        end
        case (b)
            CH_LBRACE: begin
                shift_nest(1);
                emit_tok(TK_LBRACE, ST_OK, '0, '0);
            end
            CH_RBRACE: begin
                shift_nest(-1);
                emit_tok(TK_RBRACE, ST_OK, '0, '0);
            end
            CH_LBRACKET: begin
                shift_nest(1);
                emit_tok(TK_LBRACKET, ST_OK, '0, '0);
            end
            CH_RBRACKET: begin
                shift_nest(-1);
                emit_tok(TK_RBRACKET, ST_OK, '0, '0);
            end
            CH_COLON: emit_tok(TK_COLON, ST_OK, '0, '0);
            CH_COMMA: emit_tok(TK_COMMA, ST_OK, '0, '0);
            CH_QUOTE: begin
                tok_begin = p + 32'd1;
                scan_ph   = PH_STR;
            end
            CH_MINUS: begin
                tok_begin = p;
                num_bits  = FL_SIGNED;
                scan_ph   = PH_NSIGN;
            end
            CH_LC_T: scan_ph = PH_TR;
            CH_LC_F: scan_ph = PH_FA;
            CH_LC_N: scan_ph = PH_NU;
            default: begin
                if (numeral(b)) begin
                    tok_begin = p;
                    num_bits  = FL_INT;
                    scan_ph   = (b == CH_ZERO) ? PH_NZERO : PH_NINT;
                end else begin
                    reject();
                end
            end
        endcase
    endfunction

    // Close a number, then treat the terminating byte as a fresh byte
    function automatic void finish_num(input logic [7:0] b, input logic [31:0] p,
                                       input logic eod);
        t_kind k;
        if (scan_ph inside {PH_NFRAC, PH_NEXP, PH_NEXPD}) k = TK_FLOAT;
        else if (num_bits & FL_SIGNED) k = TK_INT;
        else k = TK_UINT;
        emit_tok(k, ST_OK, tok_begin, p - tok_begin);
        scan_ph = PH_IDLE;
        idle_step(b, p, eod);
    endfunction

    function automatic void word_step(input logic [7:0] b, input logic [7:0] letter,
                                      input t_phase nxt, input t_kind k);
        if (b != letter) begin
            reject();
        end else if (nxt == PH_IDLE) begin
            scan_ph = PH_IDLE;
            emit_tok(k, ST_OK, '0, '0);
        end else begin
            scan_ph = nxt;
        end
    endfunction

    // Scan one accepted byte into byte_toks
    function automatic void scan_byte(input logic [7:0] b, input logic eod);
        logic [31:0] p;
        p = cur_pos;
        byte_toks.delete();
        case (scan_ph)
            PH_STR: begin
                if (b == CH_BSLASH) begin
                    scan_ph = PH_ESC;
                end else if (b == CH_QUOTE) begin
                    emit_tok(TK_STRING, ST_OK, tok_begin, p - tok_begin);
                    scan_ph = PH_IDLE;
                end
            end
            PH_ESC: begin
                if (b == CH_LC_U) begin
                    scan_ph  = PH_HEX;
                    hex_todo = 3'd4;
                end else begin
                    scan_ph = PH_STR;
                end
            end
            PH_HEX: begin
                if (!hexit(b)) begin
                    reject();
                end else begin
                    hex_todo = hex_todo - 3'd1;
                    if (hex_todo == 3'd0) scan_ph = PH_STR;
                end
            end
            PH_NSIGN: begin
                if (numeral(b)) begin
                    num_bits = num_bits | FL_INT;
                    scan_ph  = (b == CH_ZERO) ? PH_NZERO : PH_NINT;
                end else if (b == CH_DOT) begin
                    scan_ph = PH_NFRAC;
                end else begin
                    reject();
                end
            end
            PH_NZERO, PH_NINT: begin
                if (!(scan_ph == PH_NINT && numeral(b))) begin
                    if (b == CH_DOT) scan_ph = PH_NFRAC;
                    else if (closes_num(b)) finish_num(b, p, eod);
                    else reject();
                end
            end
            PH_NFRAC: begin
                if (numeral(b)) begin
                    num_bits = num_bits | FL_FRAC;
                end else if (b == CH_LC_E || b == CH_UC_E || closes_num(b)) begin
                    if ((num_bits & (FL_INT | FL_FRAC)) == 3'b000) reject();
                    else if (closes_num(b)) finish_num(b, p, eod);
                    else scan_ph = PH_NEXP;
                end else begin
                    reject();
                end
            end
            PH_NEXP, PH_NEXPD: begin
                if (numeral(b)) scan_ph = PH_NEXPD;
                else if (scan_ph == PH_NEXP && (b == CH_MINUS || b == CH_PLUS))
                    scan_ph = PH_NEXPD;
                else if (closes_num(b)) finish_num(b, p, eod);
                else reject();
            end
            PH_TR:  word_step(b, CH_LC_R, PH_TU,   TK_NONE);
            PH_TU:  word_step(b, CH_LC_U, PH_TE,   TK_NONE);
            PH_TE:  word_step(b, CH_LC_E, PH_IDLE, TK_TRUE);
            PH_FA:  word_step(b, CH_LC_A, PH_FL,   TK_NONE);
            PH_FL:  word_step(b, CH_LC_L, PH_FS,   TK_NONE);
            PH_FS:  word_step(b, CH_LC_S, PH_FE,   TK_NONE);
            PH_FE:  word_step(b, CH_LC_E, PH_IDLE, TK_FALSE);
            PH_NU:  word_step(b, CH_LC_U, PH_NL1,  TK_NONE);
            PH_NL1: word_step(b, CH_LC_L, PH_NL2,  TK_NONE);
            PH_NL2: word_step(b, CH_LC_L, PH_IDLE, TK_NULL);
            default: begin
                scan_ph = PH_IDLE;
                idle_step(b, p, eod);
            end
        endcase
        // End of buffer: flag an unfinished token, then restart at position zero
        if (eod) begin
            if (scan_ph != PH_IDLE) emit_tok(TK_NONE, ST_INCOMPLETE, '0, '0);
            reset_scan();
        end else begin
            cur_pos = p + 32'd1;
        end
        if (byte_toks.size() > 0) byte_toks[byte_toks.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string name, input logic signed [32:0] want_v,
                                        input logic signed [32:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            err_count++;
        end
    endfunction

    function automatic void check_token();
        t_result w;
        if (tokens_due.size() == 0) begin
            $error("token with nothing expected: kind %0d status %0d",
                   out_if.token_kind, out_if.status);
            err_count++;
            return;
        end
        w = tokens_due.pop_front();
        check_field("token_kind",   33'(w.kind),   33'(out_if.token_kind));
        check_field("status",       33'(w.status), 33'(out_if.status));
        check_field("token_start",  33'(w.start),  33'(out_if.token_start));
        check_field("token_length", 33'(w.length), 33'(out_if.token_length));
        check_field("depth",        33'(w.depth),  33'(out_if.depth));
        check_field("last_of_run",  33'(w.last),   33'(out_if.last_of_run));
    endfunction

    // Predict on each input transaction, then check each output transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                scan_byte(in_if.data_byte, in_if.end_of_data);
                if (row_typed) begin
                    byte_toks.delete();
                    byte_toks.insert(0, row_want);
                end
                foreach (byte_toks[i]) tokens_due.insert(tokens_due.size(), byte_toks[i]);
            end
            if (out_if.valid && out_if.ready) check_token();
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_json_token_scanner: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic t_result typed_tok(input t_kind k, input t_status s,
                                          input logic signed [7:0] d);
        t_result r;
        r.kind   = k;
        r.status = s;
        r.start  = '0;
        r.length = '0;
        r.depth  = d;
        r.last   = 1'b1;
        return r;
    endfunction

    // Offer one byte, after a random gap unless tx_calm is set, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic eod, input logic typed,
                             input t_result w);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.data_byte   <= b;
        in_if.end_of_data <= eod;
        row_typed         <= typed;
        row_want          <= w;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
    endtask

    function automatic logic [7:0] digit_char(input int lo);
        return CH_ZERO + 8'($urandom_range(lo, 9));
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] body_char(input bit any_byte);
        logic [7:0] c;
        do c = any_byte ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h20, 8'h7E));
        while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    // Append one byte to the text waiting to be sent
    function automatic void add_text(input logic [7:0] c);
        pending_text.insert(pending_text.size(), c);
    endfunction

    function automatic void add_hex(input int n);
        string hs;
        hs = "0123456789abcdefABCDEF";
        repeat (n) add_text(hs[$urandom_range(0, 21)]);
    endfunction

    function automatic void add_string();
        int r;
        logic [7:0] c;
        add_text(CH_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                add_text(body_char(1'b0));
            end else if (r < 82) begin
                add_text(body_char(1'b1));
            end else if (r < 92) begin
                do c = body_char(1'b0); while (c == CH_LC_U);
                add_text(CH_BSLASH);
                add_text(c);
            end else begin
                add_text(CH_BSLASH);
                add_text(CH_LC_U);
                if (r < 98) begin
                    add_hex(4);
                end else begin
                    // break the escape with a letter that is not hex
                    add_hex(2);
                    add_text(8'($urandom_range(8'h67, 8'h7A)));
                end
            end
        end
        if ($urandom_range(0, 19) != 0) add_text(CH_QUOTE);
    endfunction

    function automatic void add_number();
        int r;
        bit frac;
        frac = 1'b0;
        if ($urandom_range(0, 2) == 0) add_text(CH_MINUS);
        r = $urandom_range(0, 9);
        if (r > 0 && r < 4) begin
            add_text(CH_ZERO);
            if ($urandom_range(0, 19) == 0) add_text(digit_char(0));
        end else if (r >= 4) begin
            add_text(digit_char(1));
            repeat ($urandom_range(0, 3)) add_text(digit_char(0));
        end
        if ($urandom_range(0, 1) == 1) begin
            frac = 1'b1;
            add_text(CH_DOT);
            repeat ($urandom_range(0, 3)) add_text(digit_char(0));
        end
        if (frac ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 19) == 0)) begin
            add_text($urandom_range(0, 1) ? CH_LC_E : CH_UC_E);
            r = $urandom_range(0, 2);
            if (r == 1) add_text(CH_PLUS);
            if (r == 2) add_text(CH_MINUS);
            repeat ($urandom_range(0, 2)) add_text(digit_char(0));
        end
        case ($urandom_range(0, 3))
            0:       add_text(blank_char());
            1:       add_text(CH_COMMA);
            2:       add_text(CH_RBRACKET);
            default: add_text(CH_RBRACE);
        endcase
    endfunction

    function automatic void add_keyword();
        string w;
        int bad_at;
        int stop_at;
        case ($urandom_range(0, 2))
            0:       w = "true";
            1:       w = "false";
            default: w = "null";
        endcase
        bad_at  = ($urandom_range(0, 6) == 0) ? $urandom_range(0, w.len() - 1) : -1;
        stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w.len() - 1) : w.len();
        for (int k = 0; k < stop_at; k++) begin
            if (k == bad_at) add_text(8'($urandom_range(8'h61, 8'h7A)));
            else add_text(w[k]);
        end
    endfunction

    // Build one random segment of text, mostly well formed
    function automatic void add_segment();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 5))
                0:       add_text(CH_LBRACE);
                1:       add_text(CH_RBRACE);
                2:       add_text(CH_LBRACKET);
                3:       add_text(CH_RBRACKET);
                4:       add_text(CH_COLON);
                default: add_text(CH_COMMA);
            endcase
        end else if (r < 30) begin
            add_string();
        end else if (r < 55) begin
            add_number();
        end else if (r < 70) begin
            add_keyword();
        end else if (r < 80) begin
            repeat ($urandom_range(1, 3)) add_text(blank_char());
        end else begin
            repeat ($urandom_range(1, 3)) add_text(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) < 2) add_text(blank_char());
    endfunction

    task automatic random_until(input int goal);
        while (random_sent < goal) begin
            if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
            // stall the receiver for a long stretch while bytes keep coming
            if (!hold_done && random_sent > 200) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
                tx_calm   = 1'b1;
            end
            add_segment();
            while (pending_text.size() != 0) begin
                send_byte(pending_text.pop_front(), $urandom_range(0, 39) == 0, 1'b0, '0);
                random_sent++;
            end
        end
    endtask

    // Drive nesting into saturation, then end the buffer
    task automatic deep_run(input logic [7:0] b);
        send_byte(CH_SPACE, 1'b1, 1'b0, '0);
        repeat (DEEP_RUN) send_byte(b, 1'b0, 1'b0, '0);
        send_byte(CH_SPACE, 1'b1, 1'b0, '0);
    endtask

    // Receiver: random stalls, calm stretches and one long hold-off
    initial begin
        int stall_left;
        int hold_left;
        bit rx_calm;
        stall_left   = 0;
        hold_left    = 0;
        rx_calm      = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 4) == 0) stall_left = pick_gap();
            end
        end
    end

    // Main sequence
    initial begin
        reset_scan();
        in_if.valid       = 1'b0;
        in_if.data_byte   = '0;
        in_if.end_of_data = 1'b0;
        row_typed         = 1'b0;
        row_want          = '0;
        i_rst_n           = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (PLAN[i])
            send_byte(PLAN[i].code, PLAN[i].eod, PLAN[i].typed,
                      typed_tok(PLAN[i].w_kind, PLAN[i].w_status, PLAN[i].w_depth));

        random_until(150);
        deep_run(CH_LBRACE);
        random_until(300);
        deep_run(CH_RBRACE);
        random_until(450);
        in_if.valid <= 1'b0;

        // Drain outstanding tokens, then watch for strays
        do @(posedge i_clk); while (tokens_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_json_token_scanner: clean");
        end else begin
            $display("tb_json_token_scanner: errors");
        end
        $finish;
    end

endmodule

>>> json_token_scanner.f
rtl/jts_pkg.sv
rtl/jts_ifs.sv
rtl/jts_front.sv
rtl/jts_queue.sv
rtl/json_token_scanner.sv
test/tb_json_token_scanner.sv
